// ----- rtl/core/dra_pkg.sv -----
`timescale 1ns / 1ps

package dra_pkg;

    // Sizing of the recorder level and of the running totals
    localparam int LEVEL_BITS = 28;
    localparam int TOTAL_BITS = 48;

    // Field widths
    localparam int TIME_W     = 32;
    localparam int STEP_W     = 16;
    localparam int AMT_IN_W   = 28;
    localparam int CAP_W      = 28;
    localparam int RATE_W     = 20;
    localparam int PERIOD_W   = 24;
    localparam int QLEVEL_W   = 28;
    localparam int TX_W       = 28;
    localparam int TOT_W      = 48;
    localparam int EVENT_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 28;

    // Drain amount: rate * step, then drop the 1/1024 fraction
    localparam int PROD_W   = RATE_W + STEP_W;
    localparam int TX_SHIFT = 10;
    localparam int TXR_W    = PROD_W - TX_SHIFT;

    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = '1;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

    // Common compare width for amounts against the level
    localparam int CMP_A  = (CAP_W > AMT_IN_W) ? CAP_W : AMT_IN_W;
    localparam int CMP_B  = (TXR_W > LEVEL_BITS) ? TXR_W : LEVEL_BITS;
    localparam int CMP_W  = (CMP_A > CMP_B) ? CMP_A : CMP_B;
    localparam int AMT_W  = (AMT_IN_W > LEVEL_BITS) ? AMT_IN_W : LEVEL_BITS;
    localparam int SUM_W  = ((TOTAL_BITS > AMT_W) ? TOTAL_BITS : AMT_W) + 1;

    // Register reset values
    localparam logic [CAP_W-1:0]    CAP_RESET    = CAP_W'(262144);
    localparam logic [RATE_W-1:0]   RATE_RESET   = RATE_W'(256);
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(30720);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAPACITY      = 2'd0,
        REG_DRAIN_RATE    = 2'd1,
        REG_BEACON_PERIOD = 2'd2
    } cfg_reg_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE      = 2'd0,
        EV_FULL      = 2'd1,
        EV_RECOVERED = 2'd2
    } storage_event_t;

    typedef struct packed {
        logic [CAP_W-1:0]    capacity;
        logic [RATE_W-1:0]   drain_rate;
        logic [PERIOD_W-1:0] beacon_period;
    } cfg_t;

    // Contents of the input register
    typedef struct packed {
        logic [TIME_W-1:0]   time_now;
        logic [AMT_IN_W-1:0] incoming_amount;
        logic                carrier_valid;
        logic                carrier_detected;
        logic [TXR_W-1:0]    tx_raw;
    } stage_t;

    // Saturating add into a running total
    function automatic logic [TOTAL_BITS-1:0] sat_add(
        input logic [TOTAL_BITS-1:0] sum,
        input logic [AMT_W-1:0]      add
    );
        logic [SUM_W-1:0] s;
        s = SUM_W'(sum) + SUM_W'(add);
        if (s > SUM_W'(TOTAL_MAX))
            return TOTAL_MAX;
        else
            return TOTAL_BITS'(s);
    endfunction

endpackage

// ----- rtl/core/dra_item_if.sv -----
`timescale 1ns / 1ps

interface dra_item_if
    import dra_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [TIME_W-1:0]   time_now;
    logic [STEP_W-1:0]   step_len;
    logic [AMT_IN_W-1:0] incoming_amount;
    logic                carrier_valid;
    logic                carrier_detected;

    modport source (
        output valid, time_now, step_len, incoming_amount, carrier_valid, carrier_detected,
        input  ready
    );

    modport sink (
        input  valid, time_now, step_len, incoming_amount, carrier_valid, carrier_detected,
        output ready
    );
endinterface

// ----- rtl/core/dra_result_if.sv -----
`timescale 1ns / 1ps

interface dra_result_if
    import dra_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [TX_W-1:0]     tx_amount;
    logic                tx_sent;
    logic                beacon_fire;
    logic [QLEVEL_W-1:0] queue_level;
    logic [TOT_W-1:0]    dropped_total;
    logic [TOT_W-1:0]    sent_total;
    logic                carrier_state;
    logic [EVENT_W-1:0]  storage_event;

    modport source (
        output valid, tx_amount, tx_sent, beacon_fire, queue_level, dropped_total,
               sent_total, carrier_state, storage_event,
        input  ready
    );

    modport sink (
        input  valid, tx_amount, tx_sent, beacon_fire, queue_level, dropped_total,
               sent_total, carrier_state, storage_event,
        output ready
    );
endinterface

// ----- rtl/core/dra_cfg_regs.sv -----
`timescale 1ns / 1ps

module dra_cfg_regs
    import dra_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Register decode; unknown indexes are ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CAPACITY:      cfg_next.capacity      = CAP_W'(cfg_wdata);
                REG_DRAIN_RATE:    cfg_next.drain_rate    = RATE_W'(cfg_wdata);
                REG_BEACON_PERIOD: cfg_next.beacon_period = PERIOD_W'(cfg_wdata);
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.capacity      <= CAP_RESET;
            cfg_reg.drain_rate    <= RATE_RESET;
            cfg_reg.beacon_period <= PERIOD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/core/dra_in_stage.sv -----
`timescale 1ns / 1ps

module dra_in_stage
    import dra_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    dra_item_if.sink          item,
    input  logic [RATE_W-1:0] drain_rate,
    input  logic              take,
    output logic              stage_valid,
    output stage_t            stage
);

    logic   valid_reg;
    logic   valid_next;
    stage_t stage_reg;
    stage_t stage_next;
    logic   load;

    // Register is free when empty or when the core takes its beat
    assign item.ready = !valid_reg || take;
    assign load       = item.valid && item.ready;

    // Drain product formed on entry, fraction dropped
    always_comb
    begin
        stage_next.time_now         = item.time_now;
        stage_next.incoming_amount  = item.incoming_amount;
        stage_next.carrier_valid    = item.carrier_valid;
        stage_next.carrier_detected = item.carrier_detected;
        stage_next.tx_raw           = TXR_W'((PROD_W'(drain_rate) * PROD_W'(item.step_len))
                                             >> TX_SHIFT);
    end

    assign valid_next = load || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            stage_reg <= stage_next;
    end

    assign stage_valid = valid_reg;
    assign stage       = stage_reg;

endmodule

// ----- rtl/core/dra_acct_core.sv -----
`timescale 1ns / 1ps

module dra_acct_core
    import dra_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      stage_valid,
    input  stage_t    stage,
    output logic      take,
    dra_result_if.source result
);

    // Accounting state
    logic [LEVEL_BITS-1:0] level_reg,   level_next;
    logic [TOTAL_BITS-1:0] dropped_reg, dropped_next;
    logic [TOTAL_BITS-1:0] sent_reg,    sent_next;
    logic                  carrier_reg, carrier_next;
    logic                  full_reg;
    logic [TIME_W-1:0]     last_beacon_reg, last_beacon_next;
    logic                  armed_reg;

    // Result register
    logic                  out_valid_reg;
    logic [TX_W-1:0]       tx_amount_reg;
    logic                  tx_sent_reg;
    logic                  beacon_reg;
    logic [QLEVEL_W-1:0]   qlevel_reg;
    storage_event_t        event_reg, event_next;

    // Step arithmetic
    logic [CMP_W-1:0]      cap_ext;
    logic [CMP_W-1:0]      inc_ext;
    logic [LEVEL_BITS-1:0] cap;
    logic [LEVEL_BITS-1:0] space;
    logic [LEVEL_BITS-1:0] accepted;
    logic [LEVEL_BITS-1:0] level_acc;
    logic [AMT_W-1:0]      dropped_amt;
    logic                  full;
    logic                  drain;
    logic [LEVEL_BITS-1:0] tx;
    logic                  beacon;

    assign take = stage_valid && (!out_valid_reg || result.ready);

    // Enqueue against the free space
    always_comb
    begin
        cap_ext     = CMP_W'(cfg.capacity);
        cap         = (cap_ext < CMP_W'(LEVEL_MAX)) ? LEVEL_BITS'(cap_ext) : LEVEL_MAX;
        space       = (level_reg < cap) ? (cap - level_reg) : '0;
        inc_ext     = CMP_W'(stage.incoming_amount);
        accepted    = (inc_ext < CMP_W'(space)) ? LEVEL_BITS'(inc_ext) : space;
        level_acc   = level_reg + accepted;
        dropped_amt = AMT_W'(inc_ext - CMP_W'(accepted));
        full        = (level_acc >= cap);
    end

    // Drain when carrier is up and data is queued
    always_comb
    begin
        carrier_next = stage.carrier_valid ? stage.carrier_detected : carrier_reg;
        drain        = carrier_next && (level_acc != '0);
        if (!drain)
            tx = '0;
        else if (CMP_W'(stage.tx_raw) > CMP_W'(level_acc))
            tx = level_acc;
        else
            tx = LEVEL_BITS'(stage.tx_raw);
        level_next   = level_acc - tx;
        sent_next    = sat_add(sent_reg, AMT_W'(tx));
        dropped_next = sat_add(dropped_reg, dropped_amt);
    end

    // Beacon timing and full/recovered edge
    always_comb
    begin
        beacon = !armed_reg ||
                 ((stage.time_now >= last_beacon_reg) &&
                  ((stage.time_now - last_beacon_reg) >= TIME_W'(cfg.beacon_period)));
        last_beacon_next = beacon ? stage.time_now : last_beacon_reg;
        if (full && !full_reg)
            event_next = EV_FULL;
        else if (!full && full_reg)
            event_next = EV_RECOVERED;
        else
            event_next = EV_NONE;
    end

    // State and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg       <= '0;
            dropped_reg     <= '0;
            sent_reg        <= '0;
            carrier_reg     <= 1'b0;
            full_reg        <= 1'b0;
            last_beacon_reg <= '0;
            armed_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                level_reg       <= level_next;
                dropped_reg     <= dropped_next;
                sent_reg        <= sent_next;
                carrier_reg     <= carrier_next;
                full_reg        <= full;
                last_beacon_reg <= last_beacon_next;
                armed_reg       <= 1'b1;
                out_valid_reg   <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg   <= 1'b0;
            end
        end
    end

    // Per-step result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            tx_amount_reg <= TX_W'(tx);
            tx_sent_reg   <= drain;
            beacon_reg    <= beacon;
            qlevel_reg    <= QLEVEL_W'(level_next);
            event_reg     <= event_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.tx_amount     = tx_amount_reg;
    assign result.tx_sent       = tx_sent_reg;
    assign result.beacon_fire   = beacon_reg;
    assign result.queue_level   = qlevel_reg;
    assign result.dropped_total = TOT_W'(dropped_reg);
    assign result.sent_total    = TOT_W'(sent_reg);
    assign result.carrier_state = carrier_reg;
    assign result.storage_event = event_reg;

    // Totals only grow
    a_sent_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> (sent_reg >= $past(sent_reg)))
        else $error("sent total decreased");

    a_dropped_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> (dropped_reg >= $past(dropped_reg)))
        else $error("dropped total decreased");

    // First step after reset always beacons
    a_first_beacon: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !armed_reg) |=> (out_valid_reg && beacon_reg))
        else $error("missing first beacon");

    // No frame means nothing drained
    a_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !tx_sent_reg) |-> (tx_amount_reg == '0))
        else $error("drain amount without frame");

    // A stalled result holds while no new beat is taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |=> (out_valid_reg && $stable(qlevel_reg)))
        else $error("result changed under stall");

endmodule

// ----- rtl/core/downlink_recorder_accounting.sv -----
`timescale 1ns / 1ps

// Downlink recorder accounting. Each item beat is one time step: offered data
// is queued up to the free capacity (the rest goes to a saturating dropped
// total), the queue drains floor(drain_rate * step_len / 1024) capped at the
// level when the last known carrier is up, and a beacon fires on the first
// step and whenever time_now has advanced by beacon_period since the last one.
// One result beat follows each item beat. The block takes one item per clock
// while the result is not stalled: the drain product is formed into the input
// register, then the level/total update runs into the result register, so the
// full/recovered event and totals are valid with the result.
// Write the configuration registers only while no steps are in flight.

module downlink_recorder_accounting
    import dra_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    dra_item_if.sink              item,
    dra_result_if.source          result,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t   cfg;
    logic   stage_valid;
    stage_t stage;
    logic   take;

    // Configuration registers
    dra_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Input register with drain product
    dra_in_stage u_in (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .drain_rate  (cfg.drain_rate),
        .take        (take),
        .stage_valid (stage_valid),
        .stage       (stage)
    );

    // Accounting state and result register
    dra_acct_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .stage_valid (stage_valid),
        .stage       (stage),
        .take        (take),
        .result      (result)
    );

endmodule
